// File: rtl/ta3d_pkg.sv
package ta3d_pkg;

  // Coordinate format: signed, 8 fraction bits.
  localparam int COORD_BITS = 16;
  localparam int OUT_BITS   = 34;

  // Derived widths of the datapath.
  localparam int EDGE_W  = COORD_BITS + 1;
  localparam int PROD_W  = 2 * EDGE_W;
  localparam int CROSS_W = 2 * COORD_BITS + 3;
  localparam int MAG_W   = CROSS_W - 1;
  localparam int HALF_W  = (MAG_W + 1) / 2;
  localparam int HI_W    = MAG_W - HALF_W;
  localparam int SQ_W    = 2 * MAG_W;
  localparam int SUM_W   = SQ_W + 2;
  localparam int REM_W   = ((SUM_W > 2 * OUT_BITS) ? SUM_W : 2 * OUT_BITS) + 1;

  // Pipeline depths of the units.
  localparam int CROSS_LAT = 3;
  localparam int SUMSQ_LAT = 4;
  localparam int PIPE_LAT  = CROSS_LAT + SUMSQ_LAT + OUT_BITS;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [CROSS_W-1:0]    cross_comp_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
  } vec3_t;

  typedef struct packed {
    cross_comp_t x;
    cross_comp_t y;
    cross_comp_t z;
  } cross_t;

endpackage

// File: rtl/triangle_area_3d_unit.sv
// Channel  | Handshake                  | Payload
// ---------+----------------------------+------------------------------------
// input    | start, accepted when !busy | v0_x .. v2_z, signed Q8.8 corners
// result   | done, one-cycle strobe     | twice_area, unsigned Q18.16
//
// One triangle can enter every clock. Each result passes through
// 3 stages for edges and cross product, 4 for the squared length and
// 34 for the square root, one result bit per stage. Synchronous reset
// clears every valid bit; busy is high while rst is high. The receiver
// cannot stall, so busy is otherwise low.
module triangle_area_3d_unit import ta3d_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  coord_t              v0_x,
  input  coord_t              v0_y,
  input  coord_t              v0_z,
  input  coord_t              v1_x,
  input  coord_t              v1_y,
  input  coord_t              v1_z,
  input  coord_t              v2_x,
  input  coord_t              v2_y,
  input  coord_t              v2_z,
  output logic                done,
  output logic [OUT_BITS-1:0] twice_area
);

  vec3_t            v0, v1, v2;
  cross_t           xprod;
  logic             cross_valid;
  logic             sum_valid;
  logic [SUM_W-1:0] sum;
  logic             accept;

  // A transaction is taken whenever the unit is out of reset.
  assign busy   = rst;
  assign accept = start && !busy;

  assign v0 = '{x: v0_x, y: v0_y, z: v0_z};
  assign v1 = '{x: v1_x, y: v1_y, z: v1_z};
  assign v2 = '{x: v2_x, y: v2_y, z: v2_z};

  // Edge vectors and cross product.
  ta3d_cross u_cross (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (accept),
    .v0        (v0),
    .v1        (v1),
    .v2        (v2),
    .out_valid (cross_valid),
    .xprod     (xprod)
  );

  // Squared length of the cross product.
  ta3d_sumsq u_sumsq (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (cross_valid),
    .xprod     (xprod),
    .out_valid (sum_valid),
    .sum       (sum)
  );

  // Floored square root, saturating at OUT_BITS bits.
  ta3d_sqrt u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (sum_valid),
    .radicand  (sum),
    .out_valid (done),
    .root      (twice_area)
  );

  // Every transaction yields exactly one result after the fixed latency.
  a_latency_fwd: assert property (@(posedge clk) disable iff (rst)
    accept |-> ##PIPE_LAT done)
    else $error("transaction did not produce a result");

  a_latency_back: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(accept, PIPE_LAT))
    else $error("result without a matching transaction");

  // A degenerate triangle gives a zero squared length and a zero root.
  a_zero_root: assert property (@(posedge clk) disable iff (rst)
    (done && $past(sum_valid && (sum == '0), OUT_BITS)) |-> (twice_area == '0))
    else $error("nonzero root for zero squared length");

  // The squared length always reaches the square root unit in time.
  a_sum_timing: assert property (@(posedge clk) disable iff (rst)
    sum_valid |-> $past(accept, CROSS_LAT + SUMSQ_LAT))
    else $error("squared length out of step with its transaction");

endmodule

// File: rtl/ta3d_cross.sv
module ta3d_cross import ta3d_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   in_valid,
  input  vec3_t  v0,
  input  vec3_t  v1,
  input  vec3_t  v2,
  output logic   out_valid,
  output cross_t xprod
);

  logic signed [EDGE_W-1:0] ax, ay, az, bx, by, bz;
  logic signed [PROD_W-1:0] p_aybz, p_azby, p_azbx, p_axbz, p_axby, p_aybx;
  logic                     vld1, vld2, vld3;

  // Valid bits of the three stages.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld1 <= 1'b0;
      vld2 <= 1'b0;
      vld3 <= 1'b0;
    end else begin
      vld1 <= in_valid;
      vld2 <= vld1;
      vld3 <= vld2;
    end
  end

  // Stage 1: edge vectors from the first corner, exact.
  always_ff @(posedge clk) begin
    ax <= EDGE_W'(v1.x) - EDGE_W'(v0.x);
    ay <= EDGE_W'(v1.y) - EDGE_W'(v0.y);
    az <= EDGE_W'(v1.z) - EDGE_W'(v0.z);
    bx <= EDGE_W'(v2.x) - EDGE_W'(v0.x);
    by <= EDGE_W'(v2.y) - EDGE_W'(v0.y);
    bz <= EDGE_W'(v2.z) - EDGE_W'(v0.z);
  end

  // Stage 2: the six signed products of the cross product.
  always_ff @(posedge clk) begin
    p_aybz <= ay * bz;
    p_azby <= az * by;
    p_azbx <= az * bx;
    p_axbz <= ax * bz;
    p_axby <= ax * by;
    p_aybx <= ay * bx;
  end

  // Stage 3: differences give the cross product components.
  always_ff @(posedge clk) begin
    xprod.x <= CROSS_W'(p_aybz) - CROSS_W'(p_azby);
    xprod.y <= CROSS_W'(p_azbx) - CROSS_W'(p_axbz);
    xprod.z <= CROSS_W'(p_axby) - CROSS_W'(p_aybx);
  end

  assign out_valid = vld3;

endmodule

// File: rtl/ta3d_sumsq.sv
module ta3d_sumsq import ta3d_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  cross_t           xprod,
  output logic             out_valid,
  output logic [SUM_W-1:0] sum
);

  logic [MAG_W-1:0]       mag      [3];
  logic [2*HI_W-1:0]      part_hh  [3];
  logic [MAG_W-1:0]       part_hl  [3];
  logic [2*HALF_W-1:0]    part_ll  [3];
  logic [SQ_W-1:0]        square   [3];
  logic [CROSS_W-1:0]     comp     [3];
  logic                   vld1, vld2, vld3, vld4;

  assign comp[0] = xprod.x;
  assign comp[1] = xprod.y;
  assign comp[2] = xprod.z;

  // Valid bits of the four stages.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld1 <= 1'b0;
      vld2 <= 1'b0;
      vld3 <= 1'b0;
      vld4 <= 1'b0;
    end else begin
      vld1 <= in_valid;
      vld2 <= vld1;
      vld3 <= vld2;
      vld4 <= vld3;
    end
  end

  // Stage 1: magnitude of each component; it always fits in MAG_W bits.
  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      if (comp[k][CROSS_W-1]) begin
        mag[k] <= MAG_W'(-comp[k]);
      end else begin
        mag[k] <= MAG_W'(comp[k]);
      end
    end
  end

  // Stage 2: each square is split into partial products of half width.
  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      part_hh[k] <= mag[k][MAG_W-1:HALF_W] * mag[k][MAG_W-1:HALF_W];
      part_hl[k] <= mag[k][MAG_W-1:HALF_W] * mag[k][HALF_W-1:0];
      part_ll[k] <= mag[k][HALF_W-1:0] * mag[k][HALF_W-1:0];
    end
  end

  // Stage 3: recombine the partial products into full squares.
  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      square[k] <= (SQ_W'(part_hh[k]) << (2 * HALF_W))
                 + (SQ_W'(part_hl[k]) << (HALF_W + 1))
                 + SQ_W'(part_ll[k]);
    end
  end

  // Stage 4: squared length of the cross product.
  always_ff @(posedge clk) begin
    sum <= SUM_W'(square[0]) + SUM_W'(square[1]) + SUM_W'(square[2]);
  end

  assign out_valid = vld4;

endmodule

// File: rtl/ta3d_sqrt.sv
module ta3d_sqrt import ta3d_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic [SUM_W-1:0]    radicand,
  output logic                out_valid,
  output logic [OUT_BITS-1:0] root
);

  // Stage k of the pipeline settles result bit OUT_BITS-1-k. The remainder
  // is radicand minus the square of the bits settled so far.
  logic                vld [OUT_BITS+1];
  logic [REM_W-1:0]    rem [OUT_BITS];
  logic [OUT_BITS-1:0] res [OUT_BITS+1];

  assign vld[0] = in_valid;
  assign rem[0] = REM_W'(radicand);
  assign res[0] = '0;

  for (genvar i = 0; i < OUT_BITS; i++) begin : g_bit
    localparam int B = OUT_BITS - 1 - i;

    logic [REM_W-1:0] trial;
    logic             fits;

    // Setting bit B adds 2*res*2^B + 2^(2B) to the square.
    assign trial = (REM_W'(res[i]) << (B + 1)) | (REM_W'(1) << (2 * B));
    assign fits  = (rem[i] >= trial);

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else begin
        vld[i+1] <= vld[i];
      end
    end

    always_ff @(posedge clk) begin
      res[i+1] <= fits ? (res[i] | (OUT_BITS'(1) << B)) : res[i];
    end

    // The last stage needs no remainder.
    if (i < OUT_BITS - 1) begin : g_rem
      always_ff @(posedge clk) begin
        rem[i+1] <= fits ? (rem[i] - trial) : rem[i];
      end
    end
  end

  assign out_valid = vld[OUT_BITS];
  assign root      = res[OUT_BITS];

endmodule
